[rtl/crc64_checksum_and_prng_top_assert.svh]
`ifndef CRC64_CHECKSUM_AND_PRNG_TOP_ASSERT_SVH
`define CRC64_CHECKSUM_AND_PRNG_TOP_ASSERT_SVH

// concurrent check on the rising clock edge, off while reset is held
`define CRC64_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// value must not change on the edge after the hold condition
`define CRC64_ASSERT_STABLE(lbl, clk, rstn, hold, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) hold |=> $stable(sig)) \
    else $error(msg);

`endif

[rtl/crc64_pkg.sv]
package crc64_pkg;

  localparam logic [63:0] CRC_POLY = 64'hC96C5795D7870F42;
  localparam logic [63:0] CRC_INIT = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef logic [63:0] crc_word_t;
  typedef logic [7:0][63:0] byte_cols_t;
  typedef logic [63:0][63:0] word_cols_t;

  typedef enum logic {
    CMD_CHECKSUM = 1'b0,
    CMD_DRAW     = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_CHECKSUM = 1'b0,
    KIND_RANDOM   = 1'b1
  } kind_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  // eight lsb-first shift steps, used only to build the constant tables
  function automatic crc_word_t shift_bits(crc_word_t acc);
    crc_word_t a;
    a = acc;
    for (int k = 0; k < 8; k++) begin
      a = a[0] ? ((a >> 1) ^ CRC_POLY) : (a >> 1);
    end
    return a;
  endfunction

  function automatic crc_word_t crc_bytes(crc_word_t init, crc_word_t w);
    crc_word_t a;
    a = init;
    for (int b = 0; b < 8; b++) begin
      a = shift_bits(a ^ {56'h0, w[8*b +: 8]});
    end
    return a;
  endfunction

  function automatic byte_cols_t build_byte_cols();
    byte_cols_t cols;
    for (int j = 0; j < 8; j++) begin
      cols[j] = shift_bits(crc_word_t'(1) << j);
    end
    return cols;
  endfunction

  function automatic word_cols_t build_word_cols();
    word_cols_t cols;
    for (int i = 0; i < 64; i++) begin
      cols[i] = crc_bytes(64'h0, crc_word_t'(1) << i);
    end
    return cols;
  endfunction

  // the crc is affine in its inputs, so each input bit owns one column
  localparam byte_cols_t BYTE_COLS  = build_byte_cols();
  localparam word_cols_t WORD_COLS  = build_word_cols();
  localparam crc_word_t  WORD_CONST = crc_bytes(CRC_INIT, 64'h0);

  function automatic crc_word_t fold_byte(crc_word_t acc, logic [7:0] b);
    logic [7:0] x;
    crc_word_t  r;
    x = acc[7:0] ^ b;
    r = {8'h00, acc[63:8]};
    for (int j = 0; j < 8; j++) begin
      if (x[j]) r = r ^ BYTE_COLS[j];
    end
    return r;
  endfunction

  function automatic crc_word_t word_crc(crc_word_t w);
    crc_word_t r;
    r = WORD_CONST;
    for (int i = 0; i < 64; i++) begin
      if (w[i]) r = r ^ WORD_COLS[i];
    end
    return r;
  endfunction

endpackage

[rtl/crc64_in_if.sv]
interface crc64_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, cmd, data_byte, first_byte, last_byte, input ready);
  modport sink (input valid, cmd, data_byte, first_byte, last_byte, output ready);
endinterface

[rtl/crc64_out_if.sv]
interface crc64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  logic        result_kind;

  modport source (output valid, result_value, result_kind, input ready);
  modport sink (input valid, result_value, result_kind, output ready);
endinterface

[rtl/crc64_cfg_if.sv]
interface crc64_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] seed_value;

  modport source (output valid, seed_value, input ready);
  modport sink (input valid, seed_value, output ready);
endinterface

[rtl/crc64_engine.sv]
module crc64_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [63:0]         cfg_seed_i,
  input  logic                fire_i,
  input  crc64_pkg::item_t    item_i,
  output crc64_pkg::crc_word_t result_value_o
);
  import crc64_pkg::*;

  crc_word_t acc_q, acc_d;
  crc_word_t gen_q, gen_d;
  crc_word_t acc_base;
  logic      is_draw;

  assign is_draw  = (item_i.cmd == CMD_DRAW);
  assign acc_base = item_i.first_byte ? CRC_INIT : acc_q;

  always_comb begin
    acc_d = fold_byte(acc_base, item_i.data_byte);
    gen_d = word_crc(gen_q);
  end

  assign result_value_o = is_draw ? gen_d : acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= CRC_INIT;
      gen_q <= 64'h0;
    end else begin
      // seed writes are to arrive only while idle; the block does not enforce this, and a seed write wins over a draw
      if (cfg_we_i) begin
        gen_q <= cfg_seed_i;
      end else if (fire_i && is_draw) begin
        gen_q <= gen_d;
      end
      if (fire_i && !is_draw) begin
        acc_q <= acc_d;
      end
    end
  end

endmodule

[rtl/crc64_checksum_and_prng_top.sv]
// Reflected CRC-64 (ECMA-182 polynomial, no final inversion) with a built-in
// random word generator. A checksum item folds one byte into the running
// checksum; first_byte restarts it at all ones before the byte and last_byte
// returns the checksum after it. A draw item replaces the generator state with
// the CRC-64 of its own eight bytes (low byte first, from all ones) and returns
// the new word. Writing the seed loads the generator state at once; the seed
// port is always ready. One item is taken every clock cycle unless a waiting
// result stalls the input register. An accepted item is held in the input
// register, and the whole byte fold or word CRC is done as a single XOR
// network between it and the result register. Back-pressure on the result side
// stalls the input register only while it holds an item that returns a result;
// items that return no result still pass, and a new item is taken as each leaves.
module crc64_checksum_and_prng_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  crc64_in_if.sink    item_i,
  crc64_cfg_if.sink   cfg_i,
  crc64_out_if.source result_o
);
  import crc64_pkg::*;

  item_t     item_q;
  logic      item_valid_q;
  logic      emit;
  logic      fire;
  logic      in_take;
  crc_word_t result_value;
  logic      res_valid_q;
  crc_word_t res_value_q;
  logic      res_kind_q;

  assign emit    = (item_q.cmd == CMD_DRAW) || item_q.last_byte;
  assign fire    = item_valid_q && (!emit || !res_valid_q || result_o.ready);
  assign in_take = item_i.valid && item_i.ready;

  assign item_i.ready = !item_valid_q || fire;
  assign cfg_i.ready  = 1'b1;

  crc64_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_i.valid),
    .cfg_seed_i    (cfg_i.seed_value),
    .fire_i        (fire),
    .item_i        (item_q),
    .result_value_o(result_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_take) begin
        item_valid_q <= 1'b1;
      end else if (fire) begin
        item_valid_q <= 1'b0;
      end
      if (fire && emit) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.cmd        <= item_i.cmd;
      item_q.data_byte  <= item_i.data_byte;
      item_q.first_byte <= item_i.first_byte;
      item_q.last_byte  <= item_i.last_byte;
    end
    if (fire && emit) begin
      res_value_q <= result_value;
      res_kind_q  <= (item_q.cmd == CMD_DRAW) ? KIND_RANDOM : KIND_CHECKSUM;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.result_value = res_value_q;
  assign result_o.result_kind  = res_kind_q;

endmodule

[rtl/crc64_checker.sv]
`include "crc64_checksum_and_prng_top_assert.svh"

module crc64_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_cmd_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_value_i,
  input logic        out_kind_i
);
  import crc64_pkg::*;

  // a stalled result keeps waiting with the same word
  `CRC64_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")
  `CRC64_ASSERT_STABLE(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, out_value_i, "result changed while stalled")
  // a draining output never blocks the input side
  `CRC64_ASSERT(a_in_flow, clk_i, rst_ni, out_ready_i |-> in_ready_i, "input stalled while output drains")
  // a draw's random word, output draining, passes item_q then res_value_q
  `CRC64_ASSERT(a_draw_lat, clk_i, rst_ni, (in_valid_i && in_ready_i && in_cmd_i == CMD_DRAW && out_ready_i) ##1 out_ready_i |=> out_valid_i && out_kind_i == KIND_RANDOM, "draw result late or wrong kind")

endmodule

bind crc64_checksum_and_prng_top crc64_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (item_i.valid),
  .in_ready_i (item_i.ready),
  .in_cmd_i   (item_i.cmd),
  .out_valid_i(result_o.valid),
  .out_ready_i(result_o.ready),
  .out_value_i(result_o.result_value),
  .out_kind_i (result_o.result_kind)
);
